// File: rtl/wdhs_pkg.sv
// Shared types, codes and constants of the waypoint depth/heading sequencer.
// No dependencies; every other file of the block imports this package.
package wdhs_pkg;

	// Default size of the waypoint table.
	localparam int MAX_WAYPOINTS_DEF = 16;

	// Field widths.
	localparam int OP_W      = 2;
	localparam int DEPTH_W   = 10;
	localparam int HDG_W     = 9;
	localparam int WPHDG_W   = 10;
	localparam int THRUST_W  = 8;
	localparam int RUN_W     = 8;
	localparam int TICK_W    = 10;
	localparam int TOL_W     = 8;
	localparam int SETTLE_W  = 16;
	localparam int SACC_W    = 17;
	localparam int DACC_W    = 20;
	localparam int RUNMS_W   = 18;
	localparam int HERR_W    = 8;
	localparam int PHASE_W   = 3;
	localparam int STATUS_W  = 2;
	localparam int OUTIDX_W  = 4;

	// Configuration port geometry.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	// Opcodes of a request.
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_START  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	// Mission phases.
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SET    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DRIVE  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Register indexes (word address on the configuration port).
	localparam logic [1:0] RI_TICK   = 2'd0;
	localparam logic [1:0] RI_DTOL   = 2'd1;
	localparam logic [1:0] RI_HTOL   = 2'd2;
	localparam logic [1:0] RI_SETTLE = 2'd3;

	// Register reset values.
	localparam logic [TICK_W-1:0]   TICK_RST   = 10'd100;
	localparam logic [TOL_W-1:0]    DTOL_RST   = 8'd5;
	localparam logic [TOL_W-1:0]    HTOL_RST   = 8'd5;
	localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd5000;

	// Arithmetic constants.
	localparam logic [HDG_W-1:0]   DEG_FULL = 9'd360;
	localparam logic [HDG_W-1:0]   DEG_HALF = 9'd180;
	localparam logic [RUNMS_W-1:0] MS_PER_S = 18'd1000;

	// One stored waypoint.
	typedef struct packed {
		logic [DEPTH_W-1:0]         depth;
		logic                       relative;
		logic signed [WPHDG_W-1:0]  heading;
		logic [THRUST_W-1:0]        thrust;
		logic [RUN_W-1:0]           run_s;
	} wp_t;

	// Configuration register set.
	typedef struct packed {
		logic [TICK_W-1:0]   tick_period_ms;
		logic [TOL_W-1:0]    depth_tolerance_cm;
		logic [TOL_W-1:0]    heading_tolerance_deg;
		logic [SETTLE_W-1:0] settle_time_ms;
	} cfg_t;

endpackage

// File: rtl/wdhs_ifs.sv
// Request and result channel interfaces of the sequencer (valid/ready).
// Depends on wdhs_pkg for the field widths.
interface wdhs_req_if;
	import wdhs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            opcode;
	logic [DEPTH_W-1:0]         wp_depth_cm;
	logic                       wp_relative;
	logic signed [WPHDG_W-1:0]  wp_heading_deg;
	logic [THRUST_W-1:0]        wp_thrust;
	logic [RUN_W-1:0]           wp_run_s;
	logic [DEPTH_W-1:0]         meas_depth_cm;
	logic [HDG_W-1:0]           meas_yaw_deg;

	modport source (
		output valid, opcode, wp_depth_cm, wp_relative, wp_heading_deg,
		       wp_thrust, wp_run_s, meas_depth_cm, meas_yaw_deg,
		input  ready
	);
	modport sink (
		input  valid, opcode, wp_depth_cm, wp_relative, wp_heading_deg,
		       wp_thrust, wp_run_s, meas_depth_cm, meas_yaw_deg,
		output ready
	);
endinterface

interface wdhs_rsp_if;
	import wdhs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [THRUST_W-1:0]   thrust_out;
	logic                  hold_enable;
	logic [DEPTH_W-1:0]    target_depth_cm;
	logic [HDG_W-1:0]      target_heading_deg;
	logic [PHASE_W-1:0]    phase;
	logic [OUTIDX_W-1:0]   waypoint_index;
	logic [STATUS_W-1:0]   status;

	modport source (
		output valid, thrust_out, hold_enable, target_depth_cm,
		       target_heading_deg, phase, waypoint_index, status,
		input  ready
	);
	modport sink (
		input  valid, thrust_out, hold_enable, target_depth_cm,
		       target_heading_deg, phase, waypoint_index, status,
		output ready
	);
endinterface

// File: rtl/wdhs_cfg.sv
// APB-style configuration registers of the sequencer.
// Depends on wdhs_pkg for the register set type, indexes and reset values.
module wdhs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wdhs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [wdhs_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [wdhs_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output wdhs_pkg::cfg_t                   cfg
);
	import wdhs_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register write in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_ms        <= TICK_RST;
			cfg_q.depth_tolerance_cm    <= DTOL_RST;
			cfg_q.heading_tolerance_deg <= HTOL_RST;
			cfg_q.settle_time_ms        <= SETTLE_RST;
		end else if (wr_en) begin
			unique case (paddr[CFG_ADDR_W-1:2])
				RI_TICK:   cfg_q.tick_period_ms        <= pwdata[TICK_W-1:0];
				RI_DTOL:   cfg_q.depth_tolerance_cm    <= pwdata[TOL_W-1:0];
				RI_HTOL:   cfg_q.heading_tolerance_deg <= pwdata[TOL_W-1:0];
				RI_SETTLE: cfg_q.settle_time_ms        <= pwdata[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (paddr[CFG_ADDR_W-1:2])
			RI_TICK:   prdata = CFG_DATA_W'(cfg_q.tick_period_ms);
			RI_DTOL:   prdata = CFG_DATA_W'(cfg_q.depth_tolerance_cm);
			RI_HTOL:   prdata = CFG_DATA_W'(cfg_q.heading_tolerance_deg);
			RI_SETTLE: prdata = CFG_DATA_W'(cfg_q.settle_time_ms);
			default:   prdata = '0;
		endcase
	end

endmodule

// File: rtl/wdhs_mem.sv
// Waypoint table: one write port, one read port with registered read data.
// Depends on wdhs_pkg for the waypoint entry type.
module wdhs_mem #(
	parameter int DEPTH = wdhs_pkg::MAX_WAYPOINTS_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  wdhs_pkg::wp_t     wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output wdhs_pkg::wp_t     rd_data
);
	import wdhs_pkg::*;

	wp_t mem_q [DEPTH];
	wp_t rd_data_q;

	assign rd_data = rd_data_q;

	// Contents are undefined until written; no reset on the array.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

endmodule

// File: rtl/wdhs_seq.sv
// Mission sequencer: takes requests, reads the active waypoint from the table,
// updates the mission state and holds the result register.
// Depends on wdhs_pkg and the request/result interfaces.
module wdhs_seq #(
	parameter int MAX_WAYPOINTS = wdhs_pkg::MAX_WAYPOINTS_DEF,
	localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1,
	localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wdhs_pkg::cfg_t    cfg,
	wdhs_req_if.sink          req,
	wdhs_rsp_if.source        rsp,
	output logic              mem_wr_en,
	output logic [IDX_W-1:0]  mem_wr_addr,
	output wdhs_pkg::wp_t     mem_wr_data,
	output logic [IDX_W-1:0]  mem_rd_addr,
	input  wdhs_pkg::wp_t     mem_rd_data
);
	import wdhs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EXEC = 3'b100
	} seq_state_t;

	seq_state_t state_q, state_d;

	// Captured request.
	logic [OP_W-1:0]     op_q;
	wp_t                 item_q;
	logic [DEPTH_W-1:0]  meas_depth_q;
	logic [HDG_W-1:0]    meas_yaw_q;

	// Heading error, computed while the table read is in flight.
	logic [HERR_W-1:0]   herr_s1;

	// Mission state.
	logic [CNT_W-1:0]     count_q, count_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [PHASE_W-1:0]   mphase_q, mphase_d;
	logic [HDG_W-1:0]     prev_hdg_q, prev_hdg_d;
	logic [HDG_W-1:0]     cur_hdg_q, cur_hdg_d;
	logic [SACC_W-1:0]    settle_q, settle_d;
	logic [DACC_W-1:0]    drive_q, drive_d;
	logic [THRUST_W-1:0]  thrust_q, thrust_d;
	logic                 hold_q, hold_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	logic [STATUS_W-1:0]  status_q, status_d;
	logic                 rsp_valid_q;

	// Datapath temporaries.
	logic                 exec_go;
	logic                 tick_act;
	logic                 do_write;
	logic [HDG_W-1:0]     yaw_w;
	logic [HDG_W-1:0]     hdiff;
	logic [10:0]          hsum;
	logic [10:0]          hsum_w;
	logic [DEPTH_W-1:0]   derr;
	logic                 in_tol;
	logic [SACC_W-1:0]    settle_sum;
	logic [DACC_W-1:0]    drive_sum;
	logic [RUNMS_W-1:0]   run_ms;

	// Requests are taken only while no item is in flight.
	assign req.ready = (state_q == S_IDLE);
	assign exec_go   = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	// Table access: read the active waypoint, append at the fill count.
	assign mem_rd_addr = idx_q;
	assign mem_wr_addr = count_q[IDX_W-1:0];
	assign mem_wr_data = item_q;
	assign mem_wr_en   = exec_go && do_write;

	// Result fields show the mission state after the last item.
	assign rsp.valid              = rsp_valid_q;
	assign rsp.thrust_out         = thrust_q;
	assign rsp.hold_enable        = hold_q;
	assign rsp.target_depth_cm    = depth_q;
	assign rsp.target_heading_deg = cur_hdg_q;
	assign rsp.phase              = mphase_q;
	assign rsp.waypoint_index     = OUTIDX_W'(idx_q);
	assign rsp.status             = status_q;

	// Control sequence.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) begin
				state_d = S_READ;
			end
			S_READ: state_d = S_EXEC;
			S_EXEC: if (exec_go) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Wrapped heading error, the shorter way round.
	always_comb begin
		yaw_w = (meas_yaw_q >= DEG_FULL) ? (meas_yaw_q - DEG_FULL) : meas_yaw_q;
		hdiff = (cur_hdg_q >= yaw_w) ? (cur_hdg_q - yaw_w) : (cur_hdg_q + DEG_FULL - yaw_w);
	end

	// Mission update for the captured item.
	always_comb begin
		count_d    = count_q;
		idx_d      = idx_q;
		mphase_d   = mphase_q;
		prev_hdg_d = prev_hdg_q;
		cur_hdg_d  = cur_hdg_q;
		settle_d   = settle_q;
		drive_d    = drive_q;
		thrust_d   = thrust_q;
		hold_d     = hold_q;
		depth_d    = depth_q;
		status_d   = ST_OK;
		do_write   = 1'b0;

		tick_act = ((mphase_q == PH_SET) || (mphase_q == PH_SETTLE) ||
		            (mphase_q == PH_DRIVE)) && (CNT_W'(idx_q) < count_q);

		// New target heading, absolute or relative, wrapped into 0..359.
		// The sum spans -512..870, so up to two turns are added or removed.
		hsum = {mem_rd_data.heading[WPHDG_W-1], mem_rd_data.heading} +
		       (mem_rd_data.relative ? {2'b00, prev_hdg_q} : 11'd0);
		if (hsum[10]) begin
			hsum_w = hsum + 11'(DEG_FULL);
			if (hsum_w[10]) begin
				hsum_w = hsum_w + 11'(DEG_FULL);
			end
		end else begin
			hsum_w = hsum;
			if (hsum_w >= 11'(DEG_FULL)) begin
				hsum_w = hsum_w - 11'(DEG_FULL);
			end
			if (hsum_w >= 11'(DEG_FULL)) begin
				hsum_w = hsum_w - 11'(DEG_FULL);
			end
		end

		// Settling test and accumulators.
		derr = (meas_depth_q > mem_rd_data.depth) ? (meas_depth_q - mem_rd_data.depth)
		                                          : (mem_rd_data.depth - meas_depth_q);
		in_tol = (derr <= DEPTH_W'(cfg.depth_tolerance_cm)) &&
		         (herr_s1 <= cfg.heading_tolerance_deg);
		settle_sum = in_tol ? (settle_q + SACC_W'(cfg.tick_period_ms)) : '0;
		drive_sum  = drive_q + DACC_W'(cfg.tick_period_ms);
		run_ms     = RUNMS_W'(mem_rd_data.run_s) * MS_PER_S;

		unique case (op_q)
			OP_APPEND: begin
				if (count_q < CNT_W'(MAX_WAYPOINTS)) begin
					do_write = 1'b1;
					count_d  = count_q + CNT_W'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_START: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					idx_d    = '0;
					mphase_d = PH_SET;
					settle_d = '0;
					drive_d  = '0;
					thrust_d = '0;
				end
			end
			OP_TICK: begin
				if (tick_act) begin
					if (mphase_q == PH_SET) begin
						cur_hdg_d  = hsum_w[HDG_W-1:0];
						prev_hdg_d = hsum_w[HDG_W-1:0];
						thrust_d   = '0;
						hold_d     = 1'b1;
						depth_d    = mem_rd_data.depth;
						settle_d   = '0;
						mphase_d   = PH_SETTLE;
					end else if (mphase_q == PH_SETTLE) begin
						if (settle_sum >= SACC_W'(cfg.settle_time_ms)) begin
							settle_d = '0;
							drive_d  = '0;
							mphase_d = PH_DRIVE;
						end else begin
							settle_d = settle_sum;
						end
					end else begin
						thrust_d = mem_rd_data.thrust;
						if (drive_sum >= DACC_W'(run_ms)) begin
							drive_d = '0;
							if ((CNT_W'(idx_q) + CNT_W'(1)) < count_q) begin
								idx_d    = idx_q + IDX_W'(1);
								mphase_d = PH_SET;
							end else begin
								thrust_d = '0;
								mphase_d = PH_DONE;
							end
						end else begin
							drive_d = drive_sum;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Request capture and heading-error stage.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q            <= req.opcode;
			item_q.depth    <= req.wp_depth_cm;
			item_q.relative <= req.wp_relative;
			item_q.heading  <= req.wp_heading_deg;
			item_q.thrust   <= req.wp_thrust;
			item_q.run_s    <= req.wp_run_s;
			meas_depth_q    <= req.meas_depth_cm;
			meas_yaw_q      <= req.meas_yaw_deg;
		end
		herr_s1 <= (hdiff > DEG_HALF) ? HERR_W'(DEG_FULL - hdiff) : HERR_W'(hdiff);
	end

	// Control and mission state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			mphase_q    <= PH_IDLE;
			prev_hdg_q  <= '0;
			cur_hdg_q   <= '0;
			settle_q    <= '0;
			drive_q     <= '0;
			thrust_q    <= '0;
			hold_q      <= 1'b0;
			depth_q     <= '0;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				count_q    <= count_d;
				idx_q      <= idx_d;
				mphase_q   <= mphase_d;
				prev_hdg_q <= prev_hdg_d;
				cur_hdg_q  <= cur_hdg_d;
				settle_q   <= settle_d;
				drive_q    <= drive_d;
				thrust_q   <= thrust_d;
				hold_q     <= hold_d;
				depth_q    <= depth_d;
				status_q   <= status_d;
			end
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/waypoint_depth_heading_sequencer_core.sv
// Top level of the waypoint depth/heading cruise sequencer.
// Depends on wdhs_pkg, the channel interfaces, wdhs_cfg, wdhs_mem and wdhs_seq.
//
// Usage:
//   req carries one request per valid/ready transfer: append a waypoint,
//   start the mission, or a control tick with measured depth and yaw.
//   rsp returns exactly one result per request, showing the commanded
//   thrust, holds, target depth and heading, phase, active waypoint and
//   status after that request.
//   The APB-style port writes and reads the tick period, tolerances and
//   settle time; change them only while no request is in flight.
// Timing:
//   A request is taken when the sequencer is idle. The sequencer then reads
//   the active waypoint from the table (synchronous read with registered
//   data), then updates the mission and loads the result register, which
//   raises rsp.valid. No new request is taken until that update is done.
//   The table read and the read-modify-write of the mission state set this
//   order.
// Reset and stalls:
//   arst_n clears the mission state, fill count and registers to their
//   defaults; the table contents are undefined until written.
//   A request may be accepted while a result waits on rsp; its update then
//   waits until that result is taken, holding req.ready low meanwhile.
module waypoint_depth_heading_sequencer_core #(
	parameter int MAX_WAYPOINTS = wdhs_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wdhs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [wdhs_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [wdhs_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	wdhs_req_if.sink                         req,
	wdhs_rsp_if.source                       rsp
);
	import wdhs_pkg::*;

	localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	cfg_t              cfg;
	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_addr;
	wp_t               mem_wr_data;
	logic [IDX_W-1:0]  mem_rd_addr;
	wp_t               mem_rd_data;

	// Configuration registers.
	wdhs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Waypoint table.
	wdhs_mem #(
		.DEPTH (MAX_WAYPOINTS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Mission sequencer.
	wdhs_seq #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req         (req),
		.rsp         (rsp),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the waypoint depth/heading cruise sequencer.
// Needs wdhs_pkg, the wdhs_req_if/wdhs_rsp_if channel interfaces and the core.
module testbench;
	import wdhs_pkg::*;

	localparam int WP_SLOTS = MAX_WAYPOINTS_DEF;
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 6;
	// Run times stay short while waypoints still land in the table.
	localparam int SHORT_RUN_S = 2;

	// One request as queued for the driver. Aimed ticks get their measurements
	// filled in near the commanded target when they are offered.
	typedef struct {
		logic [OP_W-1:0]           op;
		logic [DEPTH_W-1:0]        depth;
		logic                      rel;
		logic signed [WPHDG_W-1:0] hdg;
		logic [THRUST_W-1:0]       thrust;
		logic [RUN_W-1:0]          run_s;
		logic [DEPTH_W-1:0]        mdepth;
		logic [HDG_W-1:0]          myaw;
		bit                        aim;
	} request_t;

	// Commanded outputs reported after one request.
	typedef struct packed {
		logic [THRUST_W-1:0] thrust;
		logic                hold;
		logic [DEPTH_W-1:0]  depth;
		logic [HDG_W-1:0]    heading;
		logic [PHASE_W-1:0]  phase;
		logic [OUTIDX_W-1:0] index;
		logic [STATUS_W-1:0] status;
	} nav_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	wdhs_req_if req_ch();
	wdhs_rsp_if rsp_ch();

	waypoint_depth_heading_sequencer_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// Mission state as the sequencer should hold it.
	cfg_t                model_cfg = '{TICK_RST, DTOL_RST, HTOL_RST, SETTLE_RST};
	wp_t                 wp_tab [WP_SLOTS];
	logic [4:0]          wp_cnt = '0;
	logic [3:0]          wp_idx = '0;
	logic [PHASE_W-1:0]  m_phase = PH_IDLE;
	logic [HDG_W-1:0]    prev_hdg = '0;
	logic [HDG_W-1:0]    cur_hdg = '0;
	logic [SACC_W-1:0]   settle_acc = '0;
	logic [DACC_W-1:0]   drive_acc = '0;
	logic [THRUST_W-1:0] thr = '0;
	logic                hold_on = 1'b0;
	logic [DEPTH_W-1:0]  tgt_depth = '0;

	request_t    requests_todo [$];
	nav_report_t reports_due [$];
	request_t    on_offer;
	nav_report_t want;

	int sender_idle_pct = 14;
	int receiver_idle_pct = 61;
	int appended_total = 0;
	int mismatches = 0;
	int results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_granted = 0;
	int unsigned hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the expected mission by one accepted request and queue the report.
	function automatic void apply_request(input request_t q);
		wp_t w;
		int h, yaw, d, herr, derr;
		logic [STATUS_W-1:0] st;
		st = ST_OK;
		case (q.op)
		OP_APPEND: begin
			if (wp_cnt < WP_SLOTS) begin
				wp_tab[wp_cnt[3:0]] = '{depth: q.depth, relative: q.rel, heading: q.hdg,
					thrust: q.thrust, run_s: q.run_s};
				wp_cnt++;
			end else begin
				st = ST_FULL;
			end
		end
		OP_START: begin
			if (wp_cnt == 0) begin
				st = ST_EMPTY;
			end else begin
				wp_idx = '0;
				m_phase = PH_SET;
				settle_acc = '0;
				drive_acc = '0;
				thr = '0;
			end
		end
		OP_TICK: begin
			if (m_phase >= PH_SET && m_phase <= PH_DRIVE && wp_idx < wp_cnt) begin
				w = wp_tab[wp_idx];
				case (m_phase)
				PH_SET: begin
					// Relative headings turn from the last target; both wrap to 0..359.
					h = w.heading;
					if (w.relative)
						h += int'(prev_hdg);
					h = h % 360;
					if (h < 0)
						h += 360;
					cur_hdg = h[HDG_W-1:0];
					prev_hdg = cur_hdg;
					thr = '0;
					hold_on = 1'b1;
					tgt_depth = w.depth;
					settle_acc = '0;
					m_phase = PH_SETTLE;
				end
				PH_SETTLE: begin
					// Heading error is taken the short way round.
					yaw = int'(q.myaw) % 360;
					d = (int'(cur_hdg) + 360 - yaw) % 360;
					herr = (d > 180) ? 360 - d : d;
					derr = (q.mdepth > w.depth) ? int'(q.mdepth) - int'(w.depth)
						: int'(w.depth) - int'(q.mdepth);
					if (derr <= int'(model_cfg.depth_tolerance_cm) &&
						herr <= int'(model_cfg.heading_tolerance_deg))
						settle_acc += model_cfg.tick_period_ms;
					else
						settle_acc = '0;
					if (settle_acc >= model_cfg.settle_time_ms) begin
						settle_acc = '0;
						drive_acc = '0;
						m_phase = PH_DRIVE;
					end
				end
				default: begin
					// Thrust keeps its level across the move to the next waypoint.
					thr = w.thrust;
					drive_acc += model_cfg.tick_period_ms;
					if (drive_acc >= w.run_s * MS_PER_S) begin
						drive_acc = '0;
						if (wp_idx + 1 < wp_cnt) begin
							wp_idx++;
							m_phase = PH_SET;
						end else begin
							thr = '0;
							m_phase = PH_DONE;
						end
					end
				end
				endcase
			end
		end
		default: ;
		endcase
		reports_due.push_back('{thr, hold_on, tgt_depth, cur_hdg, m_phase, wp_idx, st});
	endfunction

	// Place the measurements of a tick inside the current tolerance window.
	function automatic request_t aim_at_target(input request_t q);
		int off, v;
		off = $urandom_range(model_cfg.depth_tolerance_cm);
		v = $urandom_range(1) ? int'(tgt_depth) + off : int'(tgt_depth) - off;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		q.mdepth = v[DEPTH_W-1:0];
		off = $urandom_range(model_cfg.heading_tolerance_deg);
		if ($urandom_range(1))
			off = -off;
		v = (int'(cur_hdg) + off + 360) % 360;
		// Sometimes report the same yaw one full turn up.
		if (v < 152 && $urandom_range(3) == 0)
			v += 360;
		q.myaw = v[HDG_W-1:0];
		return q;
	endfunction

	function automatic request_t noise_request();
		request_t q;
		q.op = OP_W'($urandom_range(3));
		q.depth = DEPTH_W'($urandom);
		q.rel = 1'($urandom);
		q.hdg = WPHDG_W'($urandom);
		q.thrust = THRUST_W'($urandom);
		q.run_s = RUN_W'($urandom);
		q.mdepth = DEPTH_W'($urandom);
		q.myaw = HDG_W'($urandom);
		q.aim = 1'b0;
		return q;
	endfunction

	// Every request enters the queue here; appends that will fill the table get short runs.
	function automatic void queue_request(input request_t q);
		if (q.op == OP_APPEND) begin
			if (appended_total < WP_SLOTS && q.run_s > SHORT_RUN_S)
				q.run_s = RUN_W'($urandom_range(SHORT_RUN_S));
			appended_total++;
		end
		requests_todo.push_back(q);
	endfunction

	function automatic void queue_append(input int depth, input bit rel, input int hdg,
			input int thrust, input int run_s);
		request_t q;
		q = noise_request();
		q.op = OP_APPEND;
		q.depth = DEPTH_W'(depth);
		q.rel = rel;
		q.hdg = WPHDG_W'(hdg);
		q.thrust = THRUST_W'(thrust);
		q.run_s = RUN_W'(run_s);
		queue_request(q);
	endfunction

	function automatic void queue_tick(input bit aim, input int mdepth, input int myaw);
		request_t q;
		q = noise_request();
		q.op = OP_TICK;
		q.aim = aim;
		q.mdepth = DEPTH_W'(mdepth);
		q.myaw = HDG_W'(myaw);
		queue_request(q);
	endfunction

	function automatic void queue_op(input logic [OP_W-1:0] op);
		request_t q;
		q = noise_request();
		q.op = op;
		queue_request(q);
	endfunction

	function automatic void queue_waypoint();
		int hdg;
		hdg = ($urandom_range(7) == 0) ? int'($urandom_range(1023)) - 512
			: int'($urandom_range(719)) - 360;
		queue_append($urandom_range(1023), $urandom_range(1), hdg, $urandom_range(255),
			$urandom_range(255));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_seen, name, got, exp_val));
	endtask

	// Request driver: predicts each accepted request, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				apply_request(on_offer);
			if (!req_ch.valid || req_ch.ready) begin
				if (requests_todo.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					on_offer = requests_todo.pop_front();
					if (on_offer.aim)
						on_offer = aim_at_target(on_offer);
					req_ch.opcode <= on_offer.op;
					req_ch.wp_depth_cm <= on_offer.depth;
					req_ch.wp_relative <= on_offer.rel;
					req_ch.wp_heading_deg <= on_offer.hdg;
					req_ch.wp_thrust <= on_offer.thrust;
					req_ch.wp_run_s <= on_offer.run_s;
					req_ch.meas_depth_cm <= on_offer.mdepth;
					req_ch.meas_yaw_deg <= on_offer.myaw;
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (reports_due.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request pending",
						results_seen));
				end else begin
					want = reports_due.pop_front();
					check_field("thrust_out", rsp_ch.thrust_out, want.thrust);
					check_field("hold_enable", rsp_ch.hold_enable, want.hold);
					check_field("target_depth_cm", rsp_ch.target_depth_cm, want.depth);
					check_field("target_heading_deg", rsp_ch.target_heading_deg, want.heading);
					check_field("phase", rsp_ch.phase, want.phase);
					check_field("waypoint_index", rsp_ch.waypoint_index, want.index);
					check_field("status", rsp_ch.status, want.status);
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering meanwhile.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_granted != hold_asked) begin
			hold_left <= HOLD_CYCLES;
			hold_granted <= hold_asked;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Wait until every request has been taken and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (requests_todo.size() != 0 || req_ch.valid || reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		RI_TICK:   model_cfg.tick_period_ms = val[TICK_W-1:0];
		RI_DTOL:   model_cfg.depth_tolerance_cm = val[TOL_W-1:0];
		RI_HTOL:   model_cfg.heading_tolerance_deg = val[TOL_W-1:0];
		RI_SETTLE: model_cfg.settle_time_ms = val[SETTLE_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input int tick, input int dtol, input int htol, input int settle);
		wait_drained();
		cfg_write(RI_TICK, tick);
		cfg_write(RI_DTOL, dtol);
		cfg_write(RI_HTOL, htol);
		cfg_write(RI_SETTLE, settle);
		@(negedge clk);
	endtask

	// One random phase: mostly missions (appends, start, a run of ticks) plus noise.
	task automatic run_phase(input int tick, input int dtol, input int htol, input int settle,
			input int n_items);
		int made, t;
		set_config(tick, dtol, htol, settle);
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(9) < 3) begin
				queue_request(noise_request());
				made++;
			end else begin
				repeat ($urandom_range(2)) begin
					queue_waypoint();
					made++;
				end
				queue_op(OP_START);
				made++;
				t = $urandom_range(5, 90);
				repeat (t) begin
					if ($urandom_range(29) == 0)
						queue_waypoint();
					else
						queue_tick($urandom_range(9) != 0, $urandom_range(1023),
							$urandom_range(511));
					made++;
				end
			end
		end
		hold_asked++;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_TICK;
		req_ch.wp_depth_cm = '0;
		req_ch.wp_relative = 1'b0;
		req_ch.wp_heading_deg = '0;
		req_ch.wp_thrust = '0;
		req_ch.wp_run_s = '0;
		req_ch.meas_depth_cm = '0;
		req_ch.meas_yaw_deg = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests: empty start, idle tick, reserved opcode, field extremes,
		// settle reset, append during a mission and a restart from settling.
		set_config(1000, 3, 3, 2000);
		queue_tick(1'b0, 1023, 511);
		queue_op(OP_START);
		queue_op(OP_RESERVED);
		queue_append(0, 1'b0, -360, 255, 0);
		queue_append(1023, 1'b1, 359, 0, 1);
		queue_op(OP_START);
		queue_tick(1'b1, 0, 0);
		queue_tick(1'b0, 1023, 180);
		queue_tick(1'b0, 3, 357);
		queue_tick(1'b0, 0, 511);
		queue_tick(1'b1, 0, 0);
		queue_tick(1'b1, 0, 0);
		queue_tick(1'b1, 0, 0);
		queue_append(512, 1'b1, -512, 128, 0);
		queue_tick(1'b1, 0, 0);
		queue_tick(1'b0, 1023, 0);
		queue_op(OP_START);
		queue_tick(1'b1, 0, 0);
		queue_tick(1'b0, 0, 360);
		queue_tick(1'b1, 0, 0);
		queue_tick(1'b1, 0, 0);
		wait_drained();

		// Sender idles rarely, receiver often.
		run_phase(1000, 255, 180, 0, 220);
		run_phase(500, 10, 10, 1500, 220);

		// Sender idles often, receiver rarely.
		sender_idle_pct = 61;
		receiver_idle_pct = 14;
		run_phase(1, 0, 0, 65535, 120);
		run_phase(250, 40, 20, 2000, 220);

		// No idling on either side.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		run_phase(1000, 0, 0, 1000, 220);
		run_phase($urandom_range(100, 1000), $urandom_range(255), $urandom_range(180),
			$urandom_range(4000), 220);

		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
